>>> design/la32x_pkg.sv
// ----------------------------------------------------------------------------
// la32x_pkg
// types and constants shared by the la32 integer execute unit
// ----------------------------------------------------------------------------
`default_nettype none

package la32x_pkg;

    localparam int unsigned XLen     = 32;
    localparam int unsigned DivSteps = 32;

    typedef enum logic [5:0] {
        OP_ADD_W, OP_SUB_W, OP_SLT, OP_SLTU, OP_MASKEQZ, OP_MASKNEZ,
        OP_NOR, OP_AND, OP_OR, OP_XOR, OP_ORN, OP_ANDN,
        OP_SLL_W, OP_SRL_W, OP_SRA_W, OP_ADDI_W, OP_SLTI, OP_SLTIU,
        OP_ORI, OP_XORI, OP_ANDI, OP_SLLI_W, OP_SRLI_W, OP_SRAI_W,
        OP_BEQ, OP_BNE, OP_BLT, OP_BLTU, OP_BGE, OP_BGEU,
        OP_B, OP_BL, OP_JIRL, OP_LU12I_W, OP_PCADDU12I,
        OP_MUL_W, OP_MULH_W, OP_MULH_WU, OP_DIV_W, OP_DIV_WU, OP_MOD_W, OP_MOD_WU,
        OP_LD_B, OP_LD_H, OP_LD_W, OP_LD_BU, OP_LD_HU,
        OP_ST_B, OP_ST_H, OP_ST_W, OP_BREAK
    } t_op;

    typedef enum logic [3:0] {
        MEM_NONE, MEM_LD_B, MEM_LD_H, MEM_LD_W, MEM_LD_BU, MEM_LD_HU,
        MEM_ST_B, MEM_ST_H, MEM_ST_W
    } t_mem_kind;

    localparam logic [4:0] LinkReg = 5'd1;

    typedef struct packed {
        logic [5:0]      mode;
        logic [XLen-1:0] instr_word;
        logic [XLen-1:0] pc_value;
        logic [XLen-1:0] rj_value;
        logic [XLen-1:0] rk_value;
        logic [XLen-1:0] rd_value;
        logic [XLen-1:0] a0_value;
    } t_req;

    typedef struct packed {
        logic            write_enable;
        logic [4:0]      write_reg;
        logic [XLen-1:0] write_value;
        logic [XLen-1:0] next_pc;
        logic            branch_taken;
        logic [3:0]      mem_kind;
        logic [XLen-1:0] mem_address;
        logic [XLen-1:0] store_data;
        logic            halt;
        logic [XLen-1:0] halt_code;
    } t_rsp;

endpackage

`default_nettype wire

>>> design/la32x_req_if.sv
// ----------------------------------------------------------------------------
// la32x_req_if
// valid/ready channel carrying one instruction request
// ----------------------------------------------------------------------------
`default_nettype none

interface la32x_req_if import la32x_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/la32x_rsp_if.sv
// ----------------------------------------------------------------------------
// la32x_rsp_if
// valid/ready channel carrying one execute result
// ----------------------------------------------------------------------------
`default_nettype none

interface la32x_rsp_if import la32x_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/la32x_div.sv
// ----------------------------------------------------------------------------
// la32x_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module la32x_div import la32x_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [XLen-1:0] i_dividend,
    input  wire logic [XLen-1:0] i_divisor,
    output logic      [XLen-1:0] o_quot,
    output logic      [XLen-1:0] o_rem
);

    logic [XLen-1:0] r_rem [DivSteps];
    logic [XLen-1:0] r_dvd [DivSteps];
    logic [XLen-1:0] r_dvs [DivSteps];

    for (genvar k = 0; k < DivSteps; k++) begin : g_step
        logic [XLen-1:0] rem_in, dvd_in, dvs_in;
        logic [XLen:0]   trial, diff;
        logic            fits;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign dvd_in = i_dividend;
            assign dvs_in = i_divisor;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign dvd_in = r_dvd[k-1];
            assign dvs_in = r_dvs[k-1];
        end

        // shift in the next dividend bit and try a subtract
        assign trial = {rem_in, dvd_in[XLen-1]};
        assign diff  = trial - {1'b0, dvs_in};
        assign fits  = !diff[XLen];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= fits ? diff[XLen-1:0] : trial[XLen-1:0];
                r_dvd[k] <= {dvd_in[XLen-2:0], fits};
                r_dvs[k] <= dvs_in;
            end
        end
    end

    assign o_quot = r_dvd[DivSteps-1];
    assign o_rem  = r_rem[DivSteps-1];

endmodule

`default_nettype wire

>>> design/la32_integer_execute_unit.sv
// ----------------------------------------------------------------------------
// la32_integer_execute_unit
// LoongArch32 base integer execute: alu, shifts, mul, div, branches, ld/st
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  i_req     in   valid / ready    mode, instr_word, pc, rj/rk/rd/a0 values
//  o_rsp     out  valid / ready    register write, next pc, memory request, halt
//
//  every request passes through every stage from acceptance to o_rsp.valid, whatever op;
//  the pipe depth is set by the 32-stage divider (one quotient bit per stage)
//  a new request is taken every cycle while the result side keeps up
//  one shared stall: when the output register is full and not taken, all
//  stages hold and i_req.ready drops; nothing is lost or repeated
//  i_rst_n (synchronous, active low) clears the valid bits only
// ----------------------------------------------------------------------------
`default_nettype none

module la32_integer_execute_unit import la32x_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    la32x_req_if.sink  i_req,
    la32x_rsp_if.source o_rsp
);

    // stage 0 input reg, stage 1 decode/alu, 2..33 divider, 34 output reg
    localparam int unsigned DivFirst = 1;
    localparam int unsigned DivLast  = DivFirst + DivSteps;
    localparam int unsigned OutSt    = DivLast + 1;

    typedef struct packed {
        t_op             op;
        logic            wr;
        logic [4:0]      wreg;
        logic [XLen-1:0] wval;
        logic [XLen-1:0] next_pc;
        logic            taken;
        logic [3:0]      kind;
        logic [XLen-1:0] addr;
        logic [XLen-1:0] sdata;
        logic            halt;
        logic [XLen-1:0] hcode;
        logic            neg_q;
        logic            neg_r;
        logic            dzero;
    } t_side;

    logic            en;
    logic            r_vld [OutSt+1];
    t_req            r_in;
    t_side           r_side [DivFirst:DivLast];
    t_side           n_side;
    logic [2*XLen-1:0] r_prod;
    logic [XLen-1:0] r_mj, r_mk, r_mul_j, r_mul_k;
    logic [XLen-1:0] n_mj, n_mk;
    logic [XLen-1:0] div_q, div_r;
    t_rsp            r_out, n_out;

    // whole pipe advances unless the result is stuck
    assign en          = !r_vld[OutSt] || o_rsp.ready;
    assign i_req.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= OutSt; s++) r_vld[s] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_req.valid;
            for (int s = 1; s <= OutSt; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_in <= i_req.data;
    end

    // ---------------- stage 1: decode, alu, branch, address ----------------
    logic [XLen-1:0] vj, vk, vd, pc, w, si12, ui12, off16, off26, seq, lui, addr;
    logic [4:0]      ui5, sh;
    logic            lt_s, lt_u;
    t_op             op;

    always_comb begin
        op    = t_op'(r_in.mode);
        w     = r_in.instr_word;
        pc    = r_in.pc_value;
        vj    = r_in.rj_value;
        vk    = r_in.rk_value;
        vd    = r_in.rd_value;
        ui5   = w[14:10];
        sh    = vk[4:0];
        ui12  = {20'd0, w[21:10]};
        si12  = {{20{w[21]}}, w[21:10]};
        off16 = {{14{w[25]}}, w[25:10], 2'b00};
        off26 = {{4{w[9]}}, w[9:0], w[25:10], 2'b00};
        lui   = {w[24:5], 12'd0};
        seq   = pc + XLen'(4);
        addr  = vj + si12;
        lt_s  = $signed(vj) < $signed(vd);
        lt_u  = vj < vd;

        n_side         = '0;
        n_side.op      = op;
        n_side.wreg    = w[4:0];
        n_side.next_pc = seq;
        case (op) inside
            OP_ADD_W:     begin n_side.wr = 1'b1; n_side.wval = vj + vk; end
            OP_SUB_W:     begin n_side.wr = 1'b1; n_side.wval = vj - vk; end
            OP_SLT:       begin n_side.wr = 1'b1;
                          n_side.wval = {31'd0, $signed(vj) < $signed(vk)}; end
            OP_SLTU:      begin n_side.wr = 1'b1; n_side.wval = {31'd0, vj < vk}; end
            OP_MASKEQZ:   begin n_side.wr = 1'b1; n_side.wval = (vk == '0) ? '0 : vj; end
            OP_MASKNEZ:   begin n_side.wr = 1'b1; n_side.wval = (vk != '0) ? '0 : vj; end
            OP_NOR:       begin n_side.wr = 1'b1; n_side.wval = ~(vj | vk); end
            OP_AND:       begin n_side.wr = 1'b1; n_side.wval = vj & vk; end
            OP_OR:        begin n_side.wr = 1'b1; n_side.wval = vj | vk; end
            OP_XOR:       begin n_side.wr = 1'b1; n_side.wval = vj ^ vk; end
            OP_ORN:       begin n_side.wr = 1'b1; n_side.wval = vj | ~vk; end
            OP_ANDN:      begin n_side.wr = 1'b1; n_side.wval = vj & ~vk; end
            OP_SLL_W:     begin n_side.wr = 1'b1; n_side.wval = vj << sh; end
            OP_SRL_W:     begin n_side.wr = 1'b1; n_side.wval = vj >> sh; end
            OP_SRA_W:     begin n_side.wr = 1'b1; n_side.wval = $signed(vj) >>> sh; end
            OP_ADDI_W:    begin n_side.wr = 1'b1; n_side.wval = addr; end
            OP_SLTI:      begin n_side.wr = 1'b1;
                          n_side.wval = {31'd0, $signed(vj) < $signed(si12)}; end
            OP_SLTIU:     begin n_side.wr = 1'b1; n_side.wval = {31'd0, vj < si12}; end
            OP_ORI:       begin n_side.wr = 1'b1; n_side.wval = vj | ui12; end
            OP_XORI:      begin n_side.wr = 1'b1; n_side.wval = vj ^ ui12; end
            OP_ANDI:      begin n_side.wr = 1'b1; n_side.wval = vj & ui12; end
            OP_SLLI_W:    begin n_side.wr = 1'b1; n_side.wval = vj << ui5; end
            OP_SRLI_W:    begin n_side.wr = 1'b1; n_side.wval = vj >> ui5; end
            OP_SRAI_W:    begin n_side.wr = 1'b1; n_side.wval = $signed(vj) >>> ui5; end
            OP_BEQ:       n_side.taken = (vj == vd);
            OP_BNE:       n_side.taken = (vj != vd);
            OP_BLT:       n_side.taken = lt_s;
            OP_BLTU:      n_side.taken = lt_u;
            OP_BGE:       n_side.taken = !lt_s;
            OP_BGEU:      n_side.taken = !lt_u;
            OP_B:         n_side.taken = 1'b1;
            OP_BL:        begin
                n_side.taken = 1'b1; n_side.wr = 1'b1;
                n_side.wreg  = LinkReg; n_side.wval = seq;
            end
            OP_JIRL:      begin n_side.taken = 1'b1; n_side.wr = 1'b1; n_side.wval = seq; end
            OP_LU12I_W:   begin n_side.wr = 1'b1; n_side.wval = lui; end
            OP_PCADDU12I: begin n_side.wr = 1'b1; n_side.wval = pc + lui; end
            OP_MUL_W, OP_MULH_W, OP_MULH_WU: n_side.wr = 1'b1;
            OP_DIV_W, OP_MOD_W: begin
                n_side.wr    = 1'b1;
                n_side.neg_q = vj[XLen-1] ^ vk[XLen-1];
                n_side.neg_r = vj[XLen-1];
                n_side.dzero = (vk == '0);
            end
            OP_DIV_WU, OP_MOD_WU: begin
                n_side.wr    = 1'b1;
                n_side.dzero = (vk == '0);
            end
            OP_LD_B:      n_side.kind = MEM_LD_B;
            OP_LD_H:      n_side.kind = MEM_LD_H;
            OP_LD_W:      n_side.kind = MEM_LD_W;
            OP_LD_BU:     n_side.kind = MEM_LD_BU;
            OP_LD_HU:     n_side.kind = MEM_LD_HU;
            OP_ST_B:      begin n_side.kind = MEM_ST_B; n_side.sdata = vd; end
            OP_ST_H:      begin n_side.kind = MEM_ST_H; n_side.sdata = vd; end
            OP_ST_W:      begin n_side.kind = MEM_ST_W; n_side.sdata = vd; end
            OP_BREAK:     begin n_side.halt = 1'b1; n_side.hcode = r_in.a0_value; end
            default:      ;
        endcase

        // branch targets: jirl from the rj value read before the link write
        if (n_side.taken) begin
            case (op) inside
                OP_B, OP_BL: n_side.next_pc = pc + off26;
                OP_JIRL:     n_side.next_pc = vj + off16;
                default:     n_side.next_pc = pc + off16;
            endcase
        end
        if (n_side.kind != MEM_NONE) n_side.addr = addr;
        if (n_side.wreg == '0) n_side.wr = 1'b0;

        // divider operand magnitudes, only signed ops take the absolute value
        n_mj = vj;
        n_mk = vk;
        if (op == OP_DIV_W || op == OP_MOD_W) begin
            if (vj[XLen-1]) n_mj = '0 - vj;
            if (vk[XLen-1]) n_mk = '0 - vk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mj             <= n_mj;
            r_mk             <= n_mk;
            r_prod           <= r_in.rj_value * r_in.rk_value;
            r_mul_j          <= r_in.rj_value;
            r_mul_k          <= r_in.rk_value;
        end
    end

    // ---------------- stage 2: multiply result select ----------------
    t_side side2;
    always_comb begin
        side2 = r_side[DivFirst];
        case (side2.op)
            OP_MUL_W:   side2.wval = r_prod[XLen-1:0];
            OP_MULH_WU: side2.wval = r_prod[2*XLen-1:XLen];
            // signed high word from the unsigned product
            OP_MULH_W:  side2.wval = r_prod[2*XLen-1:XLen]
                                     - (r_mul_j[XLen-1] ? r_mul_k : '0)
                                     - (r_mul_k[XLen-1] ? r_mul_j : '0);
            default:    ;
        endcase
    end

    // side info rides alongside the divider
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[DivFirst]   <= n_side;
            r_side[DivFirst+1] <= side2;
            for (int s = DivFirst + 2; s <= DivLast; s++) r_side[s] <= r_side[s-1];
        end
    end

    la32x_div u_div (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r_mj),
        .i_divisor  (r_mk),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    // ---------------- final stage: divide fix-up, write gating ----------------
    t_side           fin;
    logic [XLen-1:0] val;
    always_comb begin
        fin = r_side[DivLast];
        val = fin.wval;
        case (fin.op) inside
            OP_DIV_W, OP_DIV_WU:
                val = fin.dzero ? '1 : (fin.neg_q ? '0 - div_q : div_q);
            // zero divisor leaves the dividend magnitude as remainder
            OP_MOD_W, OP_MOD_WU:
                val = fin.neg_r ? '0 - div_r : div_r;
            default: ;
        endcase

        n_out              = '0;
        n_out.write_enable = fin.wr;
        n_out.write_reg    = fin.wr ? fin.wreg : '0;
        n_out.write_value  = fin.wr ? val : '0;
        n_out.next_pc      = fin.next_pc;
        n_out.branch_taken = fin.taken;
        n_out.mem_kind     = fin.kind;
        n_out.mem_address  = fin.addr;
        n_out.store_data   = fin.sdata;
        n_out.halt         = fin.halt;
        n_out.halt_code    = fin.hcode;
    end

    always_ff @(posedge i_clk) begin
        if (en) r_out <= n_out;
    end

    assign o_rsp.valid = r_vld[OutSt];
    assign o_rsp.data  = r_out;

    // ---------------- checks ----------------
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_vld[0])
        else $error("accepted request did not enter stage 0");

    a_stall_holds_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en) |=> (r_vld[OutSt] && $stable(r_out)))
        else $error("output changed during stall");

    a_no_r0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.write_enable) |-> (o_rsp.data.write_reg != '0))
        else $error("write to register 0");

    a_halt_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.halt) |->
            (!o_rsp.data.write_enable && o_rsp.data.mem_kind == MEM_NONE))
        else $error("break with side effects");

endmodule

`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for la32_integer_execute_unit: a predictor computes the
// expected result of every accepted request and a scoreboard compares results
// in order, under random bursts, gaps, result stalls and one long hold-off
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import la32x_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumRandom    = 1950;
    localparam int Latency      = 35;
    localparam int IdleLimit    = 2000;
    localparam int HoldCycles   = 300;

    // scoreboard: expected results held in request order
    class exec_scoreboard;
        t_rsp pending_q[$];
        int   mismatches;
        int   checked;

        // expected execute result of one request
        function automatic t_rsp predict(t_req r);
            t_rsp        o;
            logic [31:0] w, vj, vk, vd, si12, ui12, si20, off16, off26, seq, tgt;
            logic [4:0]  ui5;
            logic [63:0] prod;
            logic [31:0] mj, mk, q, rem;
            logic        wr, taken, nj, nk;
            logic [4:0]  wreg;
            logic [31:0] wval;
            logic [3:0]  kind;
            o = '0;
            w = r.instr_word; vj = r.rj_value; vk = r.rk_value; vd = r.rd_value;
            ui5 = w[14:10];
            ui12 = {20'd0, w[21:10]};
            si12 = {{20{w[21]}}, w[21:10]};
            si20 = {12'd0, w[24:5]};
            off16 = {{14{w[25]}}, w[25:10], 2'b00};
            off26 = {{4{w[9]}}, w[9:0], w[25:10], 2'b00};
            seq = r.pc_value + 32'd4;
            wr = 1'b0; wreg = w[4:0]; wval = '0; taken = 1'b0; tgt = '0;
            kind = MEM_NONE;
            case (r.mode)
                OP_ADD_W:    begin wr = 1; wval = vj + vk; end
                OP_SUB_W:    begin wr = 1; wval = vj - vk; end
                OP_SLT:      begin wr = 1; wval = {31'd0, $signed(vj) < $signed(vk)}; end
                OP_SLTU:     begin wr = 1; wval = {31'd0, vj < vk}; end
                OP_MASKEQZ:  begin wr = 1; wval = (vk == 0) ? 32'd0 : vj; end
                OP_MASKNEZ:  begin wr = 1; wval = (vk != 0) ? 32'd0 : vj; end
                OP_NOR:      begin wr = 1; wval = ~(vj | vk); end
                OP_AND:      begin wr = 1; wval = vj & vk; end
                OP_OR:       begin wr = 1; wval = vj | vk; end
                OP_XOR:      begin wr = 1; wval = vj ^ vk; end
                OP_ORN:      begin wr = 1; wval = vj | ~vk; end
                OP_ANDN:     begin wr = 1; wval = vj & ~vk; end
                OP_SLL_W:    begin wr = 1; wval = vj << vk[4:0]; end
                OP_SRL_W:    begin wr = 1; wval = vj >> vk[4:0]; end
                OP_SRA_W:    begin wr = 1; wval = $signed(vj) >>> vk[4:0]; end
                OP_ADDI_W:   begin wr = 1; wval = vj + si12; end
                OP_SLTI:     begin wr = 1; wval = {31'd0, $signed(vj) < $signed(si12)}; end
                OP_SLTIU:    begin wr = 1; wval = {31'd0, vj < si12}; end
                OP_ORI:      begin wr = 1; wval = vj | ui12; end
                OP_XORI:     begin wr = 1; wval = vj ^ ui12; end
                OP_ANDI:     begin wr = 1; wval = vj & ui12; end
                OP_SLLI_W:   begin wr = 1; wval = vj << ui5; end
                OP_SRLI_W:   begin wr = 1; wval = vj >> ui5; end
                OP_SRAI_W:   begin wr = 1; wval = $signed(vj) >>> ui5; end
                OP_BEQ:      begin taken = vj == vd; tgt = r.pc_value + off16; end
                OP_BNE:      begin taken = vj != vd; tgt = r.pc_value + off16; end
                OP_BLT:      begin taken = $signed(vj) < $signed(vd);
                                   tgt = r.pc_value + off16; end
                OP_BLTU:     begin taken = vj < vd; tgt = r.pc_value + off16; end
                OP_BGE:      begin taken = $signed(vj) >= $signed(vd);
                                   tgt = r.pc_value + off16; end
                OP_BGEU:     begin taken = vj >= vd; tgt = r.pc_value + off16; end
                OP_B:        begin taken = 1; tgt = r.pc_value + off26; end
                OP_BL:       begin taken = 1; tgt = r.pc_value + off26;
                                   wr = 1; wreg = LinkReg; wval = seq; end
                // link write must not disturb the jump base
                OP_JIRL:     begin taken = 1; tgt = vj + off16; wr = 1; wval = seq; end
                OP_LU12I_W:  begin wr = 1; wval = si20 << 12; end
                OP_PCADDU12I: begin wr = 1; wval = r.pc_value + (si20 << 12); end
                OP_MUL_W:    begin wr = 1; prod = vj * vk; wval = prod[31:0]; end
                OP_MULH_W:   begin wr = 1;
                                   prod = $signed({{32{vj[31]}}, vj}) *
                                          $signed({{32{vk[31]}}, vk});
                                   wval = prod[63:32]; end
                OP_MULH_WU:  begin wr = 1; prod = {32'd0, vj} * {32'd0, vk};
                                   wval = prod[63:32]; end
                OP_DIV_W, OP_MOD_W: begin
                    wr = 1;
                    nj = vj[31]; nk = vk[31];
                    mj = nj ? -vj : vj; mk = nk ? -vk : vk;
                    if (vk == 0) wval = (r.mode == OP_DIV_W) ? 32'hffff_ffff : vj;
                    else if (r.mode == OP_DIV_W) begin
                        q = mj / mk; wval = (nj != nk) ? -q : q;
                    end else begin
                        rem = mj % mk; wval = nj ? -rem : rem;
                    end
                end
                OP_DIV_WU:   begin wr = 1; wval = (vk == 0) ? 32'hffff_ffff : vj / vk; end
                OP_MOD_WU:   begin wr = 1; wval = (vk == 0) ? vj : vj % vk; end
                OP_LD_B:     kind = MEM_LD_B;
                OP_LD_H:     kind = MEM_LD_H;
                OP_LD_W:     kind = MEM_LD_W;
                OP_LD_BU:    kind = MEM_LD_BU;
                OP_LD_HU:    kind = MEM_LD_HU;
                OP_ST_B:     kind = MEM_ST_B;
                OP_ST_H:     kind = MEM_ST_H;
                OP_ST_W:     kind = MEM_ST_W;
                OP_BREAK:    begin o.halt = 1; o.halt_code = r.a0_value; end
                default: ;
            endcase
            if (wr && wreg != 0) begin
                o.write_enable = 1; o.write_reg = wreg; o.write_value = wval;
            end
            o.next_pc = taken ? tgt : seq;
            o.branch_taken = taken;
            o.mem_kind = kind;
            if (kind != MEM_NONE) o.mem_address = vj + si12;
            if (kind >= MEM_ST_B) o.store_data = vd;
            return o;
        endfunction

        function void note_request(t_req r);
            pending_q.push_back(predict(r));
        endfunction

        function void check_result(t_rsp got);
            t_rsp exp_rsp;
            checked++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            exp_rsp = pending_q.pop_front();
            if (got !== exp_rsp) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch #%0d", checked);
                    $display("  exp we=%b rd=%0d val=%h npc=%h tk=%b mk=%0d ad=%h sd=%h h=%b hc=%h",
                        exp_rsp.write_enable, exp_rsp.write_reg, exp_rsp.write_value,
                        exp_rsp.next_pc, exp_rsp.branch_taken, exp_rsp.mem_kind,
                        exp_rsp.mem_address, exp_rsp.store_data, exp_rsp.halt,
                        exp_rsp.halt_code);
                    $display("  got we=%b rd=%0d val=%h npc=%h tk=%b mk=%0d ad=%h sd=%h h=%b hc=%h",
                        got.write_enable, got.write_reg, got.write_value, got.next_pc,
                        got.branch_taken, got.mem_kind, got.mem_address, got.store_data,
                        got.halt, got.halt_code);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    la32x_req_if req_ch ();
    la32x_rsp_if rsp_ch ();

    la32_integer_execute_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    exec_scoreboard sb = new();
    int  idle_cycles = 0;
    int  sent_count = 0;
    bit  hold_off = 1'b0;
    bit  stim_done = 1'b0;
    int  op_seen[64];

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
    end

    // sampling at the rising edge: score both handshakes, watch for hangs
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.data);
            if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                    || (stim_done && sb.pending_q.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IdleLimit) begin
                $display("timeout: no handshake for %0d cycles", idle_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // result side: stall pattern with quiet stretches and one long hold-off
    initial begin
        int phase;
        phase = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            phase++;
            if (hold_off) rsp_ch.ready <= 1'b0;
            else if ((phase / 200) % 3 == 0) rsp_ch.ready <= 1'b1;
            else if ((phase / 200) % 3 == 1) rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            else rsp_ch.ready <= ($urandom_range(0, 1) != 0);
        end
    end

    // offer one request, hold it until taken; valid stays high between back-to-back requests
    task automatic send_request(t_req r);
        req_ch.data <= r;
        req_ch.valid <= 1'b1;
        op_seen[r.mode]++;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic idle_gap(int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            4: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req random_request();
        t_req r;
        r.mode = ($urandom_range(0, 40) == 0) ? 6'($urandom_range(51, 63))
                                               : 6'($urandom_range(0, 50));
        r.instr_word = $urandom;
        if ($urandom_range(0, 7) == 0) r.instr_word[4:0] = 5'd0;
        r.pc_value = pick_value();
        r.rj_value = pick_value();
        r.rk_value = pick_value();
        r.rd_value = ($urandom_range(0, 3) == 0) ? r.rj_value : pick_value();
        r.a0_value = $urandom;
        // signed divide overflow gets extra weight
        if (r.mode inside {OP_DIV_W, OP_MOD_W} && $urandom_range(0, 5) == 0) begin
            r.rj_value = 32'h8000_0000; r.rk_value = 32'hffff_ffff;
        end
        return r;
    endfunction

    initial begin
        t_req r;
        int   burst, kinds;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes and the special cases
        r = '{mode: OP_ADD_W, instr_word: 32'hffff_ffff, pc_value: 32'hffff_fffc,
              rj_value: 32'hffff_ffff, rk_value: 32'hffff_ffff, rd_value: 32'hffff_ffff,
              a0_value: 32'hffff_ffff};
        send_request(r);
        r = '{default: '0}; send_request(r);
        r = '{mode: OP_DIV_W, instr_word: 32'h5, pc_value: 0, rj_value: 32'h1234,
              rk_value: 0, rd_value: 0, a0_value: 0};
        send_request(r);
        r.mode = OP_MOD_W; send_request(r);
        r.mode = OP_DIV_WU; send_request(r);
        r.mode = OP_MOD_WU; send_request(r);
        r.mode = OP_DIV_W; r.rj_value = 32'h8000_0000; r.rk_value = 32'hffff_ffff;
        send_request(r);
        r.mode = OP_MOD_W; send_request(r);
        r.mode = OP_DIV_W; r.rj_value = 32'hffff_fff9; r.rk_value = 2; send_request(r);
        r.mode = OP_MOD_W; send_request(r);
        r.mode = OP_MASKEQZ; r.rk_value = 0; send_request(r);
        r.mode = OP_MASKNEZ; send_request(r);
        r.mode = OP_ORN; r.rk_value = 32'h0f0f_0f0f; send_request(r);
        // jirl with rd == rj: jump base is the value before the link write
        r.mode = OP_JIRL; r.instr_word = 32'h03ff_fca5; r.rj_value = 32'h1000;
        send_request(r);
        r.mode = OP_BL; r.instr_word = 32'h0200_0200; send_request(r);
        r.mode = OP_BREAK; r.a0_value = 32'hdead_beef; send_request(r);
        r.mode = 6'd63; send_request(r);
        r.mode = OP_ST_W; r.instr_word = 32'h0020_0000; r.rd_value = 32'h8765_4321;
        send_request(r);
        r.mode = OP_LD_B; send_request(r);

        // random part; the long result hold-off lands early
        for (int i = 0; i < NumRandom; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && i < NumRandom; b++, i++) begin
                if (i == 300) begin
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (HoldCycles) @(negedge i_clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                send_request(random_request());
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
        end
        req_ch.valid <= 1'b0;
        stim_done = 1'b1;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (Latency + 10) @(posedge i_clk);

        kinds = 0;
        foreach (op_seen[k]) if (op_seen[k] != 0) kinds++;
        $display("%0d requests over %0d selector values, %0d results compared",
                 sent_count, kinds, sb.checked);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
